/* design/bsr_pkg.sv */
`default_nettype none
// Shared types and constants for the banded sparse row store.
// No dependencies; every other file of the block but bsr_ram imports this package.
package bsr_pkg;

	localparam int ACT_W     = 3;
	localparam int ROWF_W    = 6;
	localparam int COL_W     = 6;
	localparam int VAL_W     = 32;
	localparam int USED_W    = 4;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	typedef logic [ACT_W-1:0]     action_t;
	typedef logic [STAT_W-1:0]    status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam action_t ACT_WRITE = 3'd0;
	localparam action_t ACT_READ  = 3'd1;
	localparam action_t ACT_COUNT = 3'd2;
	localparam action_t ACT_SCALE = 3'd3;
	localparam action_t ACT_LOAD  = 3'd4;
	localparam action_t ACT_MULT  = 3'd5;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_RANGE = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;
	localparam status_t STAT_SAT   = 2'd3;

	localparam cfg_idx_t REG_ROWS = 2'd0;
	localparam cfg_idx_t REG_COLS = 2'd1;
	localparam cfg_idx_t REG_BAND = 2'd2;

	localparam logic [VAL_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [VAL_W-1:0]  result;
		logic [ROWF_W-1:0] out_row;
		logic [USED_W-1:0] used_slots;
		status_t           status;
		logic              last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT,
		ST_SC_RD,
		ST_SC_LD,
		ST_SC_MUL,
		ST_SC_PUT,
		ST_SC_WB,
		ST_MV_ROW,
		ST_MV_LD,
		ST_MV_VRD,
		ST_MV_MUL,
		ST_MV_ACC,
		ST_MV_DONE
	} state_t;

endpackage
`default_nettype wire

/* design/bsr_if.sv */
`default_nettype none
// Channel interfaces of the banded sparse row store: request, response, config.
// Depends on bsr_pkg.
interface bsr_req_if;
	import bsr_pkg::*;
	logic                    valid;
	logic                    ready;
	action_t                 action;
	logic [ROWF_W-1:0]       row;
	logic [COL_W-1:0]        col;
	logic signed [VAL_W-1:0] value;
	modport source (output valid, action, row, col, value, input ready);
	modport sink (input valid, action, row, col, value, output ready);
endinterface

interface bsr_rsp_if;
	import bsr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result;
	logic [ROWF_W-1:0]       out_row;
	logic [USED_W-1:0]       used_slots;
	status_t                 status;
	logic                    last;
	modport source (output valid, result, out_row, used_slots, status, last, input ready);
	modport sink (input valid, result, out_row, used_slots, status, last, output ready);
endinterface

interface bsr_cfg_if;
	import bsr_pkg::*;
	logic                 valid;
	logic                 ready;
	cfg_idx_t             index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/bsr_ram.sv */
`default_nettype none
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies.
module bsr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/bsr_mac.sv */
`default_nettype none
// Q16.16 multiplier: registered 64-bit product, then round half up and saturate.
// Depends on bsr_pkg.
module bsr_mac (
	input  wire logic                          clk,
	input  wire logic signed [bsr_pkg::VAL_W-1:0] a,
	input  wire logic signed [bsr_pkg::VAL_W-1:0] b,
	output logic             [bsr_pkg::VAL_W-1:0] q,
	output logic                               sat
);
	import bsr_pkg::*;

	logic signed [2*VAL_W-1:0] prod_s1;
	logic signed [2*VAL_W-1:0] rnd;
	logic signed [2*VAL_W-1:0] shr;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		rnd = prod_s1 + 64'sd32768;
		shr = rnd >>> 16;
		// in range only when bits 63..31 all agree
		sat = !((&shr[2*VAL_W-1:VAL_W-1]) || !(|shr[2*VAL_W-1:VAL_W-1]));
		if (sat)
			q = shr[2*VAL_W-1] ? Q_MIN : Q_MAX;
		else
			q = shr[VAL_W-1:0];
	end
endmodule
`default_nettype wire

/* design/banded_sparse_row_store_spmv_top.sv */
`default_nettype none
// Banded sparse row store with matrix-vector multiply; one row per memory word.
// Write, read, count: ST_EXEC, then ST_EMIT; a write reads, modifies, writes back one row.
// Load, range errors, unknown actions: to ST_EMIT. Scale per row: read, load, multiply/put per slot, write back.
// Multiply: per present row select, load, done; per used slot vector RAM read, multiply, accumulate.
// One item at a time; a waiting result word does not block the next accept.
// Reset: config to 64/64/8, all rows absent; RAM contents need no clearing.
module banded_sparse_row_store_spmv_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_BAND = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bsr_cfg_if.sink   cfg,
	bsr_req_if.sink   req,
	bsr_rsp_if.source rsp
);
	import bsr_pkg::*;

	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int VW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW     = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
	localparam int CW     = $clog2(MAX_BAND + 1);
	localparam int SLOT_W = MAX_BAND * (COL_W + VAL_W);
	localparam int WORD_W = CW + SLOT_W;
	localparam int AW     = VAL_W + CW + 1;

	state_t state_q, state_d;

	logic [6:0]          rows_q, cols_q;
	logic [3:0]          band_q;
	logic [MAX_ROWS-1:0] present_q;

	action_t                  act_q;
	logic [ROWF_W-1:0]        row_q;
	logic [COL_W-1:0]         col_q;
	logic [VAL_W-1:0]         val_q;
	logic [6:0]               r_q;
	logic [CW-1:0]            k_q, n_q, wcnt_q;
	logic [MAX_BAND-1:0][COL_W-1:0] wcol_q;
	logic [MAX_BAND-1:0][VAL_W-1:0] wval_q;
	logic signed [AW-1:0]     acc_q;
	logic                     sat_q, pv_q;
	rsp_t                     res_q, rsp_q, emit_d;
	logic                     rsp_v_q, emit_v, emit_ok, req_ready;

	logic              row_re, row_we;
	logic [RW-1:0]     row_raddr, row_waddr;
	logic [WORD_W-1:0] row_wdata, row_rdata;
	logic              vec_re, vec_we;
	logic [VW-1:0]     vec_raddr;
	logic [VAL_W-1:0]  vec_rdata;

	logic [VAL_W-1:0]  mac_a, mac_b, mac_q;
	logic              mac_sat;

	logic [6:0]  eff_rows, eff_cols, band_cap, eff_band7;
	logic [CW-1:0] eff_band;
	logic        row_ok, col_ok;
	status_t     idle_stat;

	logic [CW-1:0]                  rcnt, n_cur, ncnt;
	logic [MAX_BAND-1:0][COL_W-1:0] rcol, ncol;
	logic [MAX_BAND-1:0][VAL_W-1:0] rval, nval;
	logic [RW-1:0]                  ridx;
	logic                           found;
	logic [KW-1:0]                  fk;
	status_t                        wstat;
	logic [VAL_W-1:0]               rd_val;
	logic signed [AW-1:0]           acc_nx;
	logic                           sum_ovf;
	logic [VAL_W-1:0]               sum_val;
	rsp_t                           row_res;

	// effective configuration
	always_comb begin
		eff_rows  = (int'(rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_q;
		eff_cols  = (int'(cols_q) > MAX_COLS) ? 7'(MAX_COLS) : cols_q;
		band_cap  = (int'(band_q) > MAX_BAND) ? 7'(MAX_BAND) : {3'd0, band_q};
		eff_band7 = (band_cap < eff_cols) ? band_cap : eff_cols;
		eff_band  = CW'(eff_band7);
		row_ok    = {1'b0, req.row} < eff_rows;
		col_ok    = {1'b0, req.col} < eff_cols;
	end

	// unpack the row word and find the column
	always_comb begin
		rcnt  = row_rdata[WORD_W-1 -: CW];
		rcol  = row_rdata[SLOT_W-1 -: MAX_BAND*COL_W];
		rval  = row_rdata[MAX_BAND*VAL_W-1:0];
		ridx  = (state_q == ST_EXEC) ? RW'(row_q) : r_q[RW-1:0];
		n_cur = !present_q[ridx] ? '0 : ((rcnt < eff_band) ? rcnt : eff_band);
		found = 1'b0;
		fk    = '0;
		for (int j = MAX_BAND - 1; j >= 0; j--) begin
			if (CW'(j) < n_cur && rcol[j] == col_q) begin
				found = 1'b1;
				fk    = KW'(j);
			end
		end
		rd_val = found ? rval[fk] : '0;
	end

	// write modify: update, delete with shift down, append, or report full
	always_comb begin
		ncol  = rcol;
		nval  = rval;
		ncnt  = n_cur;
		wstat = STAT_OK;
		if (val_q == '0) begin
			if (found) begin
				for (int j = 0; j < MAX_BAND; j++) begin
					if (KW'(j) >= fk) begin
						ncol[j] = rcol[(j + 1) % MAX_BAND];
						nval[j] = rval[(j + 1) % MAX_BAND];
					end
				end
				ncnt = n_cur - 1'b1;
			end
		end else if (found) begin
			nval[fk] = val_q;
		end else if (n_cur < eff_band) begin
			ncol[n_cur[KW-1:0]] = col_q;
			nval[n_cur[KW-1:0]] = val_q;
			ncnt = n_cur + 1'b1;
		end else begin
			wstat = STAT_FULL;
		end
	end

	// row dot product accumulate and final saturation
	always_comb begin
		acc_nx  = acc_q + {{(AW-VAL_W){mac_q[VAL_W-1]}}, mac_q};
		sum_ovf = !((&acc_q[AW-1:VAL_W-1]) || !(|acc_q[AW-1:VAL_W-1]));
		sum_val = sum_ovf ? (acc_q[AW-1] ? Q_MIN : Q_MAX) : acc_q[VAL_W-1:0];
		row_res = '{result: sum_val, out_row: ROWF_W'(r_q), used_slots: '0,
			status: (sat_q || sum_ovf) ? STAT_SAT : STAT_OK, last: 1'b0};
	end

	always_comb begin
		unique case (req.action)
			ACT_WRITE, ACT_READ: idle_stat = (row_ok && col_ok) ? STAT_OK : STAT_RANGE;
			ACT_COUNT:           idle_stat = row_ok ? STAT_OK : STAT_RANGE;
			ACT_LOAD:            idle_stat = col_ok ? STAT_OK : STAT_RANGE;
			ACT_SCALE, ACT_MULT: idle_stat = STAT_OK;
			default:             idle_stat = STAT_RANGE;
		endcase
	end

	assign emit_ok   = !rsp_v_q || rsp.ready;
	assign mac_a     = wval_q[k_q[KW-1:0]];
	assign mac_b     = (state_q == ST_MV_MUL) ? vec_rdata : val_q;
	assign vec_raddr = VW'(wcol_q[k_q[KW-1:0]]);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE);
		row_re    = 1'b0;
		row_raddr = RW'(req.row);
		row_we    = 1'b0;
		row_waddr = RW'(row_q);
		row_wdata = {ncnt, ncol, nval};
		vec_re    = 1'b0;
		vec_we    = 1'b0;
		emit_v    = 1'b0;
		emit_d    = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					unique case (req.action)
						ACT_WRITE, ACT_READ, ACT_COUNT: begin
							if (idle_stat == STAT_OK) begin
								row_re  = 1'b1;
								state_d = ST_EXEC;
							end else begin
								state_d = ST_EMIT;
							end
						end
						ACT_SCALE: state_d = ST_SC_RD;
						ACT_MULT:  state_d = ST_MV_ROW;
						ACT_LOAD: begin
							vec_we  = col_ok;
							state_d = ST_EMIT;
						end
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_EXEC: begin
				row_we  = (act_q == ACT_WRITE);
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_v = 1'b1;
				if (emit_ok)
					state_d = ST_IDLE;
			end
			ST_SC_RD: begin
				row_raddr = r_q[RW-1:0];
				if (r_q >= eff_rows) begin
					state_d = ST_EMIT;
				end else begin
					row_re  = 1'b1;
					state_d = ST_SC_LD;
				end
			end
			ST_SC_LD:  state_d = (n_cur == '0) ? ST_SC_RD : ST_SC_MUL;
			ST_SC_MUL: state_d = ST_SC_PUT;
			ST_SC_PUT: state_d = (k_q + 1'b1 == n_q) ? ST_SC_WB : ST_SC_MUL;
			ST_SC_WB: begin
				row_we    = 1'b1;
				row_waddr = r_q[RW-1:0];
				row_wdata = {wcnt_q, wcol_q, wval_q};
				state_d   = ST_SC_RD;
			end
			ST_MV_ROW: begin
				row_raddr = r_q[RW-1:0];
				if (r_q >= eff_rows) begin
					state_d = pv_q ? ST_EMIT : ST_IDLE;
				end else if (present_q[r_q[RW-1:0]]) begin
					row_re  = 1'b1;
					state_d = ST_MV_LD;
				end
			end
			ST_MV_LD:  state_d = (n_cur == '0) ? ST_MV_DONE : ST_MV_VRD;
			ST_MV_VRD: begin
				vec_re  = 1'b1;
				state_d = ST_MV_MUL;
			end
			ST_MV_MUL: state_d = ST_MV_ACC;
			ST_MV_ACC: state_d = (k_q + 1'b1 == n_q) ? ST_MV_DONE : ST_MV_VRD;
			ST_MV_DONE: begin
				// hold the previous row until it can go out, marked not last
				if (pv_q) begin
					emit_v = 1'b1;
					if (emit_ok)
						state_d = ST_MV_ROW;
				end else begin
					state_d = ST_MV_ROW;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rows_q    <= 7'd64;
			cols_q    <= 7'd64;
			band_q    <= 4'd8;
			present_q <= '0;
			rsp_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_ROWS: rows_q <= cfg.data;
					REG_COLS: cols_q <= cfg.data;
					REG_BAND: band_q <= cfg.data[3:0];
					default: ;
				endcase
			end
			if (state_q == ST_EXEC && act_q == ACT_WRITE)
				present_q[RW'(row_q)] <= 1'b1;
			if (emit_v && emit_ok)
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v && emit_ok)
			rsp_q <= emit_d;
		unique case (state_q)
			ST_IDLE: begin
				act_q <= req.action;
				row_q <= req.row;
				col_q <= req.col;
				val_q <= req.value;
				r_q   <= '0;
				sat_q <= 1'b0;
				pv_q  <= 1'b0;
				res_q <= '{result: '0, out_row: '0, used_slots: '0, status: idle_stat,
					last: 1'b1};
			end
			ST_EXEC: begin
				res_q.result     <= (act_q == ACT_READ) ? rd_val : '0;
				res_q.used_slots <= (act_q == ACT_COUNT) ? USED_W'(n_cur) : '0;
				res_q.status     <= (act_q == ACT_WRITE) ? wstat : STAT_OK;
			end
			ST_SC_RD: begin
				res_q.status <= sat_q ? STAT_SAT : STAT_OK;
			end
			ST_SC_LD, ST_MV_LD: begin
				wcnt_q <= rcnt;
				wcol_q <= rcol;
				wval_q <= rval;
				n_q    <= n_cur;
				k_q    <= '0;
				acc_q  <= '0;
				if (state_q == ST_SC_LD && n_cur == '0)
					r_q <= r_q + 1'b1;
				if (state_q == ST_MV_LD)
					sat_q <= 1'b0;
			end
			ST_SC_PUT: begin
				wval_q[k_q[KW-1:0]] <= mac_q;
				sat_q               <= sat_q | mac_sat;
				k_q                 <= k_q + 1'b1;
			end
			ST_SC_WB: r_q <= r_q + 1'b1;
			ST_MV_ROW: begin
				if (r_q >= eff_rows)
					res_q.last <= 1'b1;
				else if (!present_q[r_q[RW-1:0]])
					r_q <= r_q + 1'b1;
			end
			ST_MV_ACC: begin
				acc_q <= acc_nx;
				sat_q <= sat_q | mac_sat;
				k_q   <= k_q + 1'b1;
			end
			ST_MV_DONE: begin
				if (!pv_q || emit_ok) begin
					res_q <= row_res;
					pv_q  <= 1'b1;
					r_q   <= r_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	bsr_ram #(.DEPTH(MAX_ROWS), .WIDTH(WORD_W)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	bsr_ram #(.DEPTH(MAX_COLS), .WIDTH(VAL_W)) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (VW'(req.col)),
		.wdata (req.value),
		.re    (vec_re),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	bsr_mac u_mac (
		.clk (clk),
		.a   (mac_a),
		.b   (mac_b),
		.q   (mac_q),
		.sat (mac_sat)
	);

	assign req.ready      = req_ready;
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = rsp_v_q;
	assign rsp.result     = rsp_q.result;
	assign rsp.out_row    = rsp_q.out_row;
	assign rsp.used_slots = rsp_q.used_slots;
	assign rsp.status     = rsp_q.status;
	assign rsp.last       = rsp_q.last;

endmodule
`default_nettype wire

/* tb/bsr_checker.sv */
// Checker for the banded sparse row store: watches config, request and response channels,
// predicts every response word from its own copy of the store and compares them in order.
// Depends on bsr_pkg and the channel interfaces in bsr_if.
module bsr_checker
	import bsr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bsr_cfg_if   cfg,
	bsr_req_if   req,
	bsr_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	localparam int NROWS = 64;
	localparam int NCOLS = 64;
	localparam int NBAND = 8;

	logic [CFG_DAT_W-1:0] rows_cfg;
	logic [CFG_DAT_W-1:0] cols_cfg;
	logic [3:0]           band_cfg;

	bit                   row_live [NROWS];
	int unsigned          row_fill [NROWS];
	logic [COL_W-1:0]     band_col [NROWS][NBAND];
	logic [VAL_W-1:0]     band_val [NROWS][NBAND];
	logic [VAL_W-1:0]     vec_elem [NCOLS];

	rsp_t                 expected_words[$];

	function automatic int unsigned rows_eff();
		return (rows_cfg < NROWS) ? rows_cfg : NROWS;
	endfunction

	function automatic int unsigned cols_eff();
		return (cols_cfg < NCOLS) ? cols_cfg : NCOLS;
	endfunction

	function automatic int unsigned band_eff();
		int unsigned b;
		b = (band_cfg < NBAND) ? band_cfg : NBAND;
		return (b < cols_eff()) ? b : cols_eff();
	endfunction

	function automatic int unsigned slots_used(int unsigned r);
		if (!row_live[r])
			return 0;
		return (row_fill[r] < band_eff()) ? row_fill[r] : band_eff();
	endfunction

	function automatic longint clamp_q(longint x, ref bit sat);
		if (x > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// Round half up: add half an LSB, then floor through the arithmetic shift.
	function automatic longint q_mul(longint a, longint b, ref bit sat);
		longint p;
		p = a * b + 64'sd32768;
		return clamp_q(p >>> 16, sat);
	endfunction

	task automatic push_word(longint res, int unsigned r, int unsigned used, status_t st,
			logic lst);
		rsp_t w;
		w.result     = res[VAL_W-1:0];
		w.out_row    = r[ROWF_W-1:0];
		w.used_slots = used[USED_W-1:0];
		w.status     = st;
		w.last       = lst;
		expected_words.push_back(w);
	endtask

	task automatic predict_item(action_t act, int unsigned r, int unsigned c,
			logic signed [VAL_W-1:0] v);
		bit          row_ok;
		bit          col_ok;
		bit          sat;
		int unsigned n;
		int unsigned k;
		int          hits;
		longint      acc;
		row_ok = r < rows_eff();
		col_ok = c < cols_eff();
		sat    = 0;
		case (act)
			ACT_WRITE: begin
				if (!row_ok || !col_ok) begin
					push_word(0, 0, 0, STAT_RANGE, 1);
					return;
				end
				if (!row_live[r]) begin
					row_live[r] = 1;
					row_fill[r] = 0;
				end
				n = slots_used(r);
				// drop slots hidden by a narrowed band
				row_fill[r] = n;
				for (k = 0; k < n; k++)
					if (band_col[r][k] == c)
						break;
				if (v == 0) begin
					if (k < n) begin
						for (; k + 1 < n; k++) begin
							band_col[r][k] = band_col[r][k+1];
							band_val[r][k] = band_val[r][k+1];
						end
						row_fill[r] = n - 1;
					end
				end else if (k < n) begin
					band_val[r][k] = v;
				end else if (n < band_eff()) begin
					band_col[r][n] = c[COL_W-1:0];
					band_val[r][n] = v;
					row_fill[r]    = n + 1;
				end else begin
					push_word(0, 0, 0, STAT_FULL, 1);
					return;
				end
				push_word(0, 0, 0, STAT_OK, 1);
			end
			ACT_READ: begin
				if (!row_ok || !col_ok) begin
					push_word(0, 0, 0, STAT_RANGE, 1);
					return;
				end
				acc = 0;
				n   = slots_used(r);
				for (k = 0; k < n; k++)
					if (band_col[r][k] == c) begin
						acc = longint'($signed(band_val[r][k]));
						break;
					end
				push_word(acc, 0, 0, STAT_OK, 1);
			end
			ACT_COUNT: begin
				if (!row_ok)
					push_word(0, 0, 0, STAT_RANGE, 1);
				else
					push_word(0, 0, slots_used(r), STAT_OK, 1);
			end
			ACT_SCALE: begin
				for (int unsigned i = 0; i < rows_eff(); i++) begin
					n = slots_used(i);
					for (k = 0; k < n; k++)
						band_val[i][k] = VAL_W'(q_mul($signed(band_val[i][k]), v, sat));
				end
				push_word(0, 0, 0, sat ? STAT_SAT : STAT_OK, 1);
			end
			ACT_LOAD: begin
				if (!col_ok) begin
					push_word(0, 0, 0, STAT_RANGE, 1);
				end else begin
					vec_elem[c] = v;
					push_word(0, 0, 0, STAT_OK, 1);
				end
			end
			ACT_MULT: begin
				hits = 0;
				for (int unsigned i = 0; i < rows_eff(); i++) begin
					if (!row_live[i])
						continue;
					acc = 0;
					sat = 0;
					n   = slots_used(i);
					for (k = 0; k < n; k++)
						acc += q_mul($signed(band_val[i][k]),
							$signed(vec_elem[band_col[i][k]]), sat);
					acc = clamp_q(acc, sat);
					push_word(acc, i, 0, sat ? STAT_SAT : STAT_OK, 0);
					hits++;
				end
				// mark the final dot product of this multiply
				if (hits > 0)
					expected_words[expected_words.size()-1].last = 1;
			end
			default: push_word(0, 0, 0, STAT_RANGE, 1);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			rows_cfg = 64;
			cols_cfg = 64;
			band_cfg = 8;
			for (int i = 0; i < NROWS; i++) begin
				row_live[i] = 0;
				row_fill[i] = 0;
			end
			expected_words.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.result     = rsp.result;
				got.out_row    = rsp.out_row;
				got.used_slots = rsp.used_slots;
				got.status     = rsp.status;
				got.last       = rsp.last;
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual %h row %0d used %0d st %0d last %0d",
						$time, got.result, got.out_row, got.used_slots, got.status, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch, expected %h row %0d used %0d st %0d last %0d",
							$time, want.result, want.out_row, want.used_slots, want.status,
							want.last);
						$display("%0t:           actual   %h row %0d used %0d st %0d last %0d",
							$time, got.result, got.out_row, got.used_slots, got.status,
							got.last);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ROWS: rows_cfg = cfg.data;
					REG_COLS: cols_cfg = cfg.data;
					REG_BAND: band_cfg = cfg.data[3:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				predict_item(req.action, req.row, req.col, req.value);
			pending = expected_words.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Top of the sparse row store testbench: clock, reset, stimulus on the config and request
// channels, random response back-pressure, and the verdict. Depends on bsr_pkg, bsr_if,
// bsr_checker and the block itself.
module tb_top;
	import bsr_pkg::*;

	localparam action_t ACT_BAD_LO = 3'd6;
	localparam action_t ACT_BAD_HI = 3'd7;
	localparam int      DRAIN_CYC  = 400;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   gaps_on;
	bit   hold_rsp;

	bsr_cfg_if cfg_ch ();
	bsr_req_if req_ch ();
	bsr_rsp_if rsp_ch ();

	banded_sparse_row_store_spmv_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bsr_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		bit held;
		held = 0;
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp && !held) begin
				held = 1;
				rsp_ch.ready <= 0;
				repeat (500) @(posedge clk);
			end
			rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 27);
		end
	end

	task automatic send_word(action_t act, logic [ROWF_W-1:0] r, logic [COL_W-1:0] c,
			logic [VAL_W-1:0] v);
		bit ok;
		if (gaps_on && $urandom_range(99) < 27) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid  <= 1;
		req_ch.action <= act;
		req_ch.row    <= r;
		req_ch.col    <= c;
		req_ch.value  <= v;
		do begin
			@(negedge clk);
			ok = req_ch.ready;
			@(posedge clk);
		end while (!ok);
	endtask

	// Wait out every outstanding word, then the tail of a multiply with no rows.
	task automatic settle();
		req_ch.valid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int d);
		bit ok;
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d[CFG_DAT_W-1:0];
		do begin
			@(negedge clk);
			ok = cfg_ch.ready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic set_shape(int nr, int nc, int nb);
		settle();
		write_reg(REG_ROWS, nr);
		write_reg(REG_COLS, nc);
		write_reg(REG_BAND, nb);
		cfg_ch.valid <= 0;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int p;
		p = $urandom_range(99);
		if (p < 15)
			return 0;
		if (p < 65)
			return $urandom_range(0, 32'h7ffff) - 32'h40000;
		if (p < 80)
			case ($urandom_range(3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return 32'h0001_0000;
				default: return 32'hffff_ffff;
			endcase
		return $urandom;
	endfunction

	task automatic random_word();
		int               p;
		action_t          act;
		logic [VAL_W-1:0] v;
		logic [5:0]       r;
		logic [5:0]       c;
		p = $urandom_range(99);
		r = ($urandom_range(99) < 75) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
		c = ($urandom_range(99) < 75) ? 6'($urandom_range(0, 11)) : 6'($urandom_range(0, 63));
		v = pick_value();
		if (p < 40)
			act = ACT_WRITE;
		else if (p < 60)
			act = ACT_READ;
		else if (p < 70)
			act = ACT_COUNT;
		else if (p < 75) begin
			act = ACT_SCALE;
			// keep most factors near one so the store does not pin at the rails
			if ($urandom_range(3) != 0)
				v = 32'h0001_0000 + $urandom_range(0, 32'h3fff) - 32'h2000;
		end else if (p < 85)
			act = ACT_LOAD;
		else if (p < 95)
			act = ACT_MULT;
		else
			act = $urandom_range(1) ? ACT_BAD_LO : ACT_BAD_HI;
		send_word(act, r, c, v);
	endtask

	task automatic random_phase(int n, bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 16)
				hold_rsp = 1;
			random_word();
		end
	endtask

	initial begin
		arst_n = 0;
		gaps_on = 1;
		hold_rsp = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_ROWS;
		cfg_ch.data = 0;
		req_ch.valid = 0;
		req_ch.action = ACT_WRITE;
		req_ch.row = 0;
		req_ch.col = 0;
		req_ch.value = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(posedge clk);

		set_shape(64, 64, 8);
		// fill the whole vector so no multiply reads an unloaded element
		for (int c = 0; c < 64; c++)
			send_word(ACT_LOAD, 6'($urandom_range(0, 63)), 6'(c),
				(c == 0) ? Q_MAX : (c == 63) ? Q_MIN : $urandom_range(0, 32'h3ffff) - 32'h20000);

		// directed: extremes, update, delete, full band, unknown actions, scale, multiply
		send_word(ACT_WRITE, 0, 0, Q_MAX);
		send_word(ACT_WRITE, 63, 63, Q_MIN);
		send_word(ACT_READ, 0, 0, 0);
		send_word(ACT_READ, 63, 63, 0);
		send_word(ACT_READ, 5, 5, 0);
		send_word(ACT_READ, 0, 9, 0);
		for (int c = 0; c < 9; c++)
			send_word(ACT_WRITE, 1, 6'(c), 32'h0001_8000 + c);
		send_word(ACT_WRITE, 1, 3, 0);
		send_word(ACT_COUNT, 1, 0, 0);
		send_word(ACT_WRITE, 1, 0, 32'hfffe_0000);
		send_word(ACT_BAD_LO, 1, 1, 1);
		send_word(ACT_BAD_HI, 63, 63, 32'hffff_ffff);
		send_word(ACT_MULT, 0, 0, 0);
		send_word(ACT_SCALE, 0, 0, 32'h0002_0000);
		send_word(ACT_MULT, 0, 0, 0);

		// narrow band below the fill of row 1, and shrink the shape
		set_shape(8, 12, 4);
		random_phase(48, 0);
		set_shape(64, 64, 8);
		random_phase(48, 1);
		set_shape(3, 5, 8);
		gaps_on = 0;
		random_phase(48, 0);
		gaps_on = 1;
		set_shape(1, 1, 1);
		random_phase(48, 0);
		set_shape(64, 64, 8);
		random_phase(48, 0);

		settle();
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
design/bsr_pkg.sv
design/bsr_if.sv
design/bsr_ram.sv
design/bsr_mac.sv
design/banded_sparse_row_store_spmv_top.sv
tb/bsr_checker.sv
tb/tb_top.sv
